[rtl/mandelbrot_escape_time_unit_defines.svh]
// Assertion macros for the Mandelbrot escape-time unit.
// Used by the top level; expects clk and rst_n in the scope of each use.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define MBET_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbet assertion failed");

`define MBET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbet assertion failed");

`else

`define MBET_ASSERT_SAME(lbl, ante, cons)

`define MBET_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/mbet_pkg.sv]
// Shared types, constants and helper functions of the Mandelbrot escape-time unit.
// No dependencies; used by every other RTL file.
`timescale 1ns / 1ps
`default_nettype none

package mbet_pkg;

  localparam int WORD_W  = 32;
  localparam int STEP_W  = 31;
  localparam int LIMIT_W = 16;
  localparam int CALC_W  = 66;
  localparam int PROD_W  = 2 * WORD_W;

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [WORD_W-1:0]  REAL_ORIGIN_RST = 32'hD800_0000;
  localparam logic [WORD_W-1:0]  IMAG_ORIGIN_RST = 32'hF000_0000;
  localparam logic [STEP_W-1:0]  REAL_STEP_RST   = 31'd1174405;
  localparam logic [STEP_W-1:0]  IMAG_STEP_RST   = 31'd671089;
  localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST  = 16'd1000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_REAL_ORIGIN = 3'd0,
    REG_IMAG_ORIGIN = 3'd1,
    REG_REAL_STEP   = 3'd2,
    REG_IMAG_STEP   = 3'd3,
    REG_ITER_LIMIT  = 3'd4
  } mbet_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0]  real_origin;
    logic [WORD_W-1:0]  imag_origin;
    logic [STEP_W-1:0]  real_step;
    logic [STEP_W-1:0]  imag_step;
    logic [LIMIT_W-1:0] iteration_limit;
  } mbet_cfg_t;

  // Complex point c handed from the front end to the iteration core.
  typedef struct packed {
    logic [WORD_W-1:0] c_re;
    logic [WORD_W-1:0] c_im;
  } mbet_point_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] iteration_count;
    logic               escaped;
  } mbet_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mbet_core_st_t;

  // Clamp a wide signed value to the signed 32-bit word range.
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [CALC_W-1:0] v);
    logic [WORD_W-1:0] res;
    if ((&v[CALC_W-1:WORD_W-1]) || !(|v[CALC_W-1:WORD_W-1])) begin
      res = v[WORD_W-1:0];
    end else if (v[CALC_W-1]) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/mbet_ifs.sv]
// Valid/ready channel interfaces: pixel requests in, escape-time results out.
// Depends on mbet_pkg for the result field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mbet_pix_if #(
  parameter int PIXEL_BITS = 11
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_column;
  logic [PIXEL_BITS-1:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

interface mbet_res_if ();
  logic                         valid;
  logic                         ready;
  logic [mbet_pkg::LIMIT_W-1:0] iteration_count;
  logic                         escaped;

  modport source (output valid, output iteration_count, output escaped, input ready);
  modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

`default_nettype wire

[rtl/mbet_front.sv]
// Front end: accepts pixel requests and maps each pixel to the complex point c.
// Depends on mbet_pkg and mbet_pix_if.
`timescale 1ns / 1ps
`default_nettype none

module mbet_front #(
  parameter int PIXEL_BITS = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mbet_pkg::mbet_cfg_t   cfg,
  mbet_pix_if.sink                   pix,
  output mbet_pkg::mbet_point_t      pt,
  output logic                       pt_valid,
  input  wire logic                  pt_ready
);

  localparam int MUL_W = PIXEL_BITS + mbet_pkg::STEP_W;

  logic             s1_valid_r;
  logic [MUL_W-1:0] col_prod_r;
  logic [MUL_W-1:0] row_prod_r;
  logic             s2_valid_r;
  mbet_pkg::mbet_point_t pt_r;

  logic adv2;
  logic adv1;
  logic signed [mbet_pkg::CALC_W-1:0] re_sum;
  logic signed [mbet_pkg::CALC_W-1:0] im_sum;

  assign adv2      = !s2_valid_r || pt_ready;
  assign adv1      = !s1_valid_r || adv2;
  assign pix.ready = adv1;

  always_comb begin
    re_sum = mbet_pkg::CALC_W'($signed(cfg.real_origin))
           + $signed(mbet_pkg::CALC_W'(col_prod_r));
    im_sum = mbet_pkg::CALC_W'($signed(cfg.imag_origin))
           + $signed(mbet_pkg::CALC_W'(row_prod_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= pix.valid;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage one: pixel index times step; stage two: add origin and clamp.
  always_ff @(posedge clk) begin
    if (adv1 && pix.valid) begin
      col_prod_r <= MUL_W'(pix.pixel_column) * MUL_W'(cfg.real_step);
      row_prod_r <= MUL_W'(pix.pixel_row) * MUL_W'(cfg.imag_step);
    end
    if (adv2 && s1_valid_r) begin
      pt_r.c_re <= mbet_pkg::sat_word(re_sum);
      pt_r.c_im <= mbet_pkg::sat_word(im_sum);
    end
  end

  assign pt       = pt_r;
  assign pt_valid = s2_valid_r;

endmodule

`default_nettype wire

[rtl/mbet_queue.sv]
// Short first-in first-out queue of mapped points between front end and core.
// Depends on mbet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbet_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mbet_pkg::mbet_point_t push_data,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  output mbet_pkg::mbet_point_t      pop_data,
  output logic                       pop_valid,
  input  wire logic                  pop_ready
);

  mbet_pkg::mbet_point_t           mem_r [mbet_pkg::Q_DEPTH];
  logic [mbet_pkg::Q_AW-1:0]       wr_ptr_r;
  logic [mbet_pkg::Q_AW-1:0]       rd_ptr_r;
  logic [mbet_pkg::Q_AW:0]         count_r;

  logic do_push;
  logic do_pop;

  assign push_ready = (count_r != (mbet_pkg::Q_AW+1)'(mbet_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/mbet_core.sv]
// Back end: iterates z = z*z + c for one point at a time and reports the count.
// Depends on mbet_pkg. Each iteration passes through a multiply state and then an add state.
`timescale 1ns / 1ps
`default_nettype none

module mbet_core #(
  parameter int FRACTION_BITS = 28
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [mbet_pkg::LIMIT_W-1:0] iteration_limit,
  input  wire mbet_pkg::mbet_point_t        pt,
  input  wire logic                         pt_valid,
  output logic                              pt_ready,
  output mbet_pkg::mbet_result_t            res,
  input  wire logic                         res_ready,
  output mbet_pkg::mbet_core_st_t           status
);

  localparam int CW = mbet_pkg::CALC_W;
  localparam int PW = mbet_pkg::PROD_W;
  localparam logic signed [CW-1:0] FOUR = CW'(1) <<< (FRACTION_BITS + 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  state_t state_r;

  logic signed [mbet_pkg::WORD_W-1:0] re_r;
  logic signed [mbet_pkg::WORD_W-1:0] im_r;
  logic signed [mbet_pkg::WORD_W-1:0] cre_r;
  logic signed [mbet_pkg::WORD_W-1:0] cim_r;
  logic        [mbet_pkg::LIMIT_W-1:0] cnt_r;
  logic                                escaped_r;
  logic signed [PW-1:0] prod_rr_r;
  logic signed [PW-1:0] prod_ii_r;
  logic signed [PW-1:0] prod_ri_r;

  logic signed [PW-1:0] sq_re;
  logic signed [PW-1:0] sq_im;
  logic signed [PW-1:0] two_ri;
  logic signed [CW-1:0] mag_sum;
  logic [mbet_pkg::WORD_W-1:0] re_nxt;
  logic [mbet_pkg::WORD_W-1:0] im_nxt;

  // Arithmetic right shifts round the products toward minus infinity.
  always_comb begin
    sq_re   = prod_rr_r >>> FRACTION_BITS;
    sq_im   = prod_ii_r >>> FRACTION_BITS;
    two_ri  = prod_ri_r >>> (FRACTION_BITS - 1);
    mag_sum = CW'(sq_re) + CW'(sq_im);
    re_nxt  = mbet_pkg::sat_word(CW'(sq_re) - CW'(sq_im) + CW'(cre_r));
    im_nxt  = mbet_pkg::sat_word(CW'(two_ri) + CW'(cim_r));
  end

  assign pt_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pt_valid) begin
            cre_r   <= $signed(pt.c_re);
            cim_r   <= $signed(pt.c_im);
            re_r    <= '0;
            im_r    <= '0;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt_r == iteration_limit) begin
            escaped_r <= 1'b0;
            state_r   <= ST_DONE;
          end else begin
            prod_rr_r <= re_r * re_r;
            prod_ii_r <= im_r * im_r;
            prod_ri_r <= re_r * im_r;
            state_r   <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (mag_sum >= FOUR) begin
            escaped_r <= 1'b1;
            state_r   <= ST_DONE;
          end else begin
            re_r    <= $signed(re_nxt);
            im_r    <= $signed(im_nxt);
            cnt_r   <= cnt_r + 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.iteration_count = cnt_r;
  assign res.escaped         = escaped_r;
  assign status.busy         = (state_r != ST_IDLE);
  assign status.done         = (state_r == ST_DONE);

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_time_unit.sv]
// Mandelbrot escape-time unit: top level with register file and output register.
// Depends on mbet_pkg, mbet_ifs, mbet_front, mbet_queue, mbet_core and the
// assertion macro header.
//
// Usage: a request on in_pix carries a pixel column and row. The front end maps
// it to c = origin + pixel * step and parks c in a two-entry queue. The core
// iterates z = z*z + c from zero, each iteration a multiply state, then an add,
// escape-test and clamp state, until |z|^2 >= 4 or the iteration limit is
// reached. The result (count, escaped) is loaded into an output register and
// offered on out_res. One pixel is in the core at a time: the core takes no new
// point until the last result has left it. The front end keeps taking requests
// until the queue and its own stages are full, so the next pixel is ready when
// the core frees up. While out_res is stalled the core holds its finished result,
// and the front end and queue back up behind it. Reset (rst_n low, synchronous)
// empties all stages and loads the default registers: origin (-2.5, -1.0),
// steps for an 800 by 600 view, limit 1000. Registers are to be written over
// APB only while idle by the user; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_unit_defines.svh"

module mandelbrot_escape_time_unit #(
  parameter int FRACTION_BITS = 28,
  parameter int PIXEL_BITS    = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mbet_pix_if.sink                         in_pix,
  mbet_res_if.source                       out_res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbet_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mbet_pkg::DATA_W-1:0] pwdata,
  output logic      [mbet_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  mbet_pkg::mbet_cfg_t     cfg_r;
  mbet_pkg::mbet_reg_t     reg_idx;
  logic                    cfg_wr;

  mbet_pkg::mbet_point_t   front_pt;
  logic                    front_valid;
  logic                    front_ready;
  mbet_pkg::mbet_point_t   q_pt;
  logic                    q_valid;
  logic                    q_ready;
  logic                    q_pop;

  mbet_pkg::mbet_result_t  core_res;
  mbet_pkg::mbet_core_st_t core_st;
  logic                    res_ready;
  logic                    res_load;

  logic                    out_valid_r;
  mbet_pkg::mbet_result_t  out_res_r;

  assign pready  = 1'b1;
  assign reg_idx = mbet_pkg::mbet_reg_t'(paddr[mbet_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.real_origin     <= mbet_pkg::REAL_ORIGIN_RST;
      cfg_r.imag_origin     <= mbet_pkg::IMAG_ORIGIN_RST;
      cfg_r.real_step       <= mbet_pkg::REAL_STEP_RST;
      cfg_r.imag_step       <= mbet_pkg::IMAG_STEP_RST;
      cfg_r.iteration_limit <= mbet_pkg::ITER_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        mbet_pkg::REG_REAL_ORIGIN: cfg_r.real_origin     <= pwdata;
        mbet_pkg::REG_IMAG_ORIGIN: cfg_r.imag_origin     <= pwdata;
        mbet_pkg::REG_REAL_STEP:   cfg_r.real_step       <= pwdata[mbet_pkg::STEP_W-1:0];
        mbet_pkg::REG_IMAG_STEP:   cfg_r.imag_step       <= pwdata[mbet_pkg::STEP_W-1:0];
        mbet_pkg::REG_ITER_LIMIT:  cfg_r.iteration_limit <= pwdata[mbet_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mbet_pkg::REG_REAL_ORIGIN: prdata = cfg_r.real_origin;
      mbet_pkg::REG_IMAG_ORIGIN: prdata = cfg_r.imag_origin;
      mbet_pkg::REG_REAL_STEP:   prdata = mbet_pkg::DATA_W'(cfg_r.real_step);
      mbet_pkg::REG_IMAG_STEP:   prdata = mbet_pkg::DATA_W'(cfg_r.imag_step);
      mbet_pkg::REG_ITER_LIMIT:  prdata = mbet_pkg::DATA_W'(cfg_r.iteration_limit);
      default:                   prdata = '0;
    endcase
  end

  mbet_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .pix      (in_pix),
    .pt       (front_pt),
    .pt_valid (front_valid),
    .pt_ready (front_ready)
  );

  mbet_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (front_pt),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (q_pt),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  mbet_core #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .iteration_limit (cfg_r.iteration_limit),
    .pt              (q_pt),
    .pt_valid        (q_valid),
    .pt_ready        (q_ready),
    .res             (core_res),
    .res_ready       (res_ready),
    .status          (core_st)
  );

  assign q_pop     = q_valid && q_ready;
  assign res_ready = !out_valid_r || out_res.ready;
  assign res_load  = core_st.done && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= core_st.done;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= core_res;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.iteration_count = out_res_r.iteration_count;
  assign out_res.escaped         = out_res_r.escaped;

  // A point taken from the queue always starts an iteration run.
  `MBET_ASSERT_NEXT(a_pop_starts_core, q_pop, core_st.busy && !core_st.done)
  // A finished result lands in the output register unchanged.
  `MBET_ASSERT_NEXT(a_result_loaded, res_load,
                    out_valid_r && (out_res_r == $past(core_res)))
  // A taken result with nothing behind it leaves the output register empty.
  `MBET_ASSERT_NEXT(a_out_drains, out_valid_r && out_res.ready && !res_load, !out_valid_r)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for mandelbrot_escape_time_unit.
// It drives pixel requests and APB register writes, predicts each escape-time result
// itself and compares it field by field. Uses mbet_pkg, mbet_ifs and the top-level RTL.
`timescale 1ns / 1ps

module testbench;
  import mbet_pkg::*;

  localparam int FRACTION_BITS = 28;
  localparam int PIXEL_BITS    = 11;
  localparam int PIXEL_MAX     = (1 << PIXEL_BITS) - 1;
  localparam int ONE_Q         = 1 << FRACTION_BITS;

  localparam longint WORD_HI          = 64'sd2147483647;
  localparam longint WORD_LO          = -64'sd2147483648;
  localparam longint ESCAPE_RADIUS_SQ = 64'sd1 <<< (FRACTION_BITS + 2);

  localparam logic [REG_IDX_W-1:0] REG_UNUSED_FIRST = REG_IDX_W'(REG_ITER_LIMIT + 1);
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  localparam int     RESET_CYCLES      = 12;
  localparam int     SETTLE_CYCLES     = 10;
  localparam int     HOLD_OFF_CYCLES   = 400;
  localparam int     END_WAIT_LIMIT    = 50000;
  localparam int     PHASES            = 3;
  localparam int     SEGMENTS          = 7;
  localparam int     ITEMS_PER_SEGMENT = 29;
  localparam longint TIMEOUT_NS        = 40_000_000;

  localparam int SEND_IDLE_PCT [PHASES] = '{25, 69, 0};
  localparam int RECV_IDLE_PCT [PHASES] = '{69, 25, 0};

  typedef enum {ROW_READBACK, ROW_WRITE, ROW_PIXEL, ROW_PIXEL_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [REG_IDX_W-1:0]   idx;
    logic [DATA_W-1:0]      data;
    logic [PIXEL_BITS-1:0]  pix_col;
    logic [PIXEL_BITS-1:0]  pix_row;
    mbet_result_t           res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mbet_pix_if #(.PIXEL_BITS(PIXEL_BITS)) pix_if ();
  mbet_res_if                            res_if ();

  mandelbrot_escape_time_unit #(
    .FRACTION_BITS(FRACTION_BITS),
    .PIXEL_BITS   (PIXEL_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_if),
    .out_res(res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  mbet_cfg_t    view_cfg;
  mbet_result_t pending_results[$];
  dir_row_t     dir_rows[$];

  int errors          = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int escaped_seen    = 0;
  int reg_writes      = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  bit hold_off_request = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp_to_word(input longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // Escape-time iteration for one pixel under the current register view.
  function automatic mbet_result_t escape_time(input logic [PIXEL_BITS-1:0] col,
                                               input logic [PIXEL_BITS-1:0] line);
    int           origin_re;
    int           origin_im;
    longint       c_re, c_im, z_re, z_im, sq_re, sq_im, twice_ri;
    int unsigned  n;
    bit           gone;
    mbet_result_t res;
    origin_re = view_cfg.real_origin;
    origin_im = view_cfg.imag_origin;
    c_re = clamp_to_word(longint'(origin_re) + longint'(col) * longint'(view_cfg.real_step));
    c_im = clamp_to_word(longint'(origin_im) + longint'(line) * longint'(view_cfg.imag_step));
    z_re = 0;
    z_im = 0;
    n    = 0;
    gone = 1'b0;
    while (n < view_cfg.iteration_limit && !gone) begin
      // Products are exact in 64 bits; the arithmetic shift rounds toward minus infinity.
      sq_re = (z_re * z_re) >>> FRACTION_BITS;
      sq_im = (z_im * z_im) >>> FRACTION_BITS;
      if (sq_re + sq_im >= ESCAPE_RADIUS_SQ) begin
        gone = 1'b1;
      end else begin
        twice_ri = (z_re * z_im) >>> (FRACTION_BITS - 1);
        z_re     = clamp_to_word(sq_re - sq_im + c_re);
        z_im     = clamp_to_word(twice_ri + c_im);
        n++;
      end
    end
    res.iteration_count = n[LIMIT_W-1:0];
    res.escaped         = gone;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
    return {idx, 2'b00};
  endfunction

  function automatic dir_row_t cfg_row(input row_kind_t kind, input logic [REG_IDX_W-1:0] idx,
                                       input logic [DATA_W-1:0] data);
    dir_row_t r;
    r.kind    = kind;
    r.idx     = idx;
    r.data    = data;
    r.pix_col = '0;
    r.pix_row = '0;
    r.res     = '0;
    return r;
  endfunction

  function automatic dir_row_t pixel(input int col, input int line);
    dir_row_t r;
    r         = cfg_row(ROW_PIXEL, REG_REAL_ORIGIN, '0);
    r.pix_col = PIXEL_BITS'(col);
    r.pix_row = PIXEL_BITS'(line);
    return r;
  endfunction

  function automatic dir_row_t pixel_known(input int col, input int line, input int count,
                                           input bit esc);
    dir_row_t r;
    r                     = pixel(col, line);
    r.kind                = ROW_PIXEL_KNOWN;
    r.res.iteration_count = LIMIT_W'(count);
    r.res.escaped         = esc;
    return r;
  endfunction

  // One APB transfer, ending with psel and penable low again so that back-to-back calls never
  // drive the same signal twice in one step.
  task automatic reg_access(input bit is_write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (is_write) begin
      case (addr[ADDR_W-1:2])
        REG_REAL_ORIGIN: view_cfg.real_origin     = wdata;
        REG_IMAG_ORIGIN: view_cfg.imag_origin     = wdata;
        REG_REAL_STEP:   view_cfg.real_step       = wdata[STEP_W-1:0];
        REG_IMAG_STEP:   view_cfg.imag_step       = wdata[STEP_W-1:0];
        REG_ITER_LIMIT:  view_cfg.iteration_limit = wdata[LIMIT_W-1:0];
        default: ;
      endcase
      reg_writes++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] unused_rdata;
    reg_access(1'b1, reg_addr(idx), data, unused_rdata);
  endtask

  task automatic check_registers();
    int                k;
    logic [DATA_W-1:0] got;
    logic [DATA_W-1:0] want;
    for (k = REG_REAL_ORIGIN; k <= REG_ITER_LIMIT; k++) begin
      reg_access(1'b0, reg_addr(REG_IDX_W'(k)), '0, got);
      case (k)
        REG_REAL_ORIGIN: want = view_cfg.real_origin;
        REG_IMAG_ORIGIN: want = view_cfg.imag_origin;
        REG_REAL_STEP:   want = {1'b0, view_cfg.real_step};
        REG_IMAG_STEP:   want = {1'b0, view_cfg.imag_step};
        default:         want = {16'd0, view_cfg.iteration_limit};
      endcase
      if (got !== want) begin
        $display("%0t: register %0d readback: expected %h, got %h", $time, k, want, got);
        errors++;
      end
    end
  endtask

  // Offers one pixel request and records its expected result once it is accepted.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] col, input logic [PIXEL_BITS-1:0] line,
                            input bit typed, input mbet_result_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid        <= 1'b1;
    pix_if.pixel_column <= col;
    pix_if.pixel_row    <= line;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pending_results.push_back(typed ? typed_res : escape_time(col, line));
    pixels_sent++;
  endtask

  // Registers may only change once the unit has delivered every result.
  task automatic drain();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int held;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        // Long stall so the queue and front end fill and back-pressure the requests.
        hold_off_request = 1'b0;
        res_if.ready <= 1'b0;
        for (held = 1; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    mbet_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending: expected none, got count %0d escaped %0d",
                 $time, res_if.iteration_count, res_if.escaped);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.escaped) escaped_seen++;
        if (res_if.iteration_count !== want.iteration_count) begin
          $display("%0t: iteration_count: expected %0d, got %0d", $time,
                   want.iteration_count, res_if.iteration_count);
          errors++;
        end
        if (res_if.escaped !== want.escaped) begin
          $display("%0t: escaped: expected %0d, got %0d", $time, want.escaped, res_if.escaped);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int                phase;
    int                seg;
    int                waited;
    int unsigned       sel;
    int                r;
    logic [DATA_W-1:0] ro, io, rs, is_step, lim;

    pix_if.valid        = 1'b0;
    pix_if.pixel_column = '0;
    pix_if.pixel_row    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    view_cfg.real_origin     = REAL_ORIGIN_RST;
    view_cfg.imag_origin     = IMAG_ORIGIN_RST;
    view_cfg.real_step       = REAL_STEP_RST;
    view_cfg.imag_step       = IMAG_STEP_RST;
    view_cfg.iteration_limit = ITER_LIMIT_RST;
    send_idle_pct = SEND_IDLE_PCT[0];
    recv_idle_pct = RECV_IDLE_PCT[0];

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default view after reset: corner, far corner, near the neck, inside the cardioid.
    dir_rows.push_back(cfg_row(ROW_READBACK, REG_REAL_ORIGIN, '0));
    dir_rows.push_back(pixel_known(0, 0, 1, 1'b1));
    dir_rows.push_back(pixel(PIXEL_MAX, PIXEL_MAX));
    dir_rows.push_back(pixel(400, 300));
    dir_rows.push_back(pixel(560, 300));
    // A zero limit does no iteration at all.
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_ITER_LIMIT, 32'd0));
    dir_rows.push_back(pixel_known(123, 45, 0, 1'b0));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_ITER_LIMIT, 32'd1));
    dir_rows.push_back(pixel_known(560, 300, 1, 1'b0));
    // c = 0 never escapes, so the count runs up to the largest limit.
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_ITER_LIMIT, 32'h0000_FFFF));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_REAL_ORIGIN, 32'd0));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_IMAG_ORIGIN, 32'd0));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_REAL_STEP, 32'd0));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_IMAG_STEP, 32'd0));
    dir_rows.push_back(pixel_known(PIXEL_MAX, PIXEL_MAX, 16'hFFFF, 1'b0));
    // Saturated points escape after the first iteration.
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_REAL_ORIGIN, 32'h7FFF_FFFF));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_REAL_STEP, 32'h7FFF_FFFF));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_IMAG_ORIGIN, 32'h8000_0000));
    dir_rows.push_back(pixel_known(PIXEL_MAX, 0, 1, 1'b1));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_IMAG_STEP, 32'h7FFF_FFFF));
    dir_rows.push_back(pixel_known(0, PIXEL_MAX, 1, 1'b1));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_REAL_ORIGIN, 32'h8000_0000));
    dir_rows.push_back(pixel_known(0, 0, 1, 1'b1));
    // c = -2 lands exactly on |z|^2 = 4, which counts as escaped.
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_REAL_ORIGIN, 32'hE000_0000));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_IMAG_ORIGIN, 32'd0));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_IMAG_STEP, 32'd0));
    dir_rows.push_back(pixel_known(0, 1234, 1, 1'b1));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_ITER_LIMIT, DATA_W'(ITER_LIMIT_RST)));
    dir_rows.push_back(cfg_row(ROW_WRITE, REG_REAL_ORIGIN, 32'hE000_0001));
    dir_rows.push_back(pixel(0, 0));
    // Writes to unused addresses must leave every register alone.
    for (r = REG_UNUSED_FIRST; r <= REG_UNUSED_LAST; r++)
      dir_rows.push_back(cfg_row(ROW_WRITE, REG_IDX_W'(r), 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(ROW_READBACK, REG_REAL_ORIGIN, '0));
    dir_rows.push_back(pixel(1, 1));

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_READBACK: begin
          drain();
          check_registers();
        end
        ROW_WRITE: begin
          drain();
          reg_write(dir_rows[i].idx, dir_rows[i].data);
        end
        ROW_PIXEL:   send_pixel(dir_rows[i].pix_col, dir_rows[i].pix_row, 1'b0, '0);
        default:     send_pixel(dir_rows[i].pix_col, dir_rows[i].pix_row, 1'b1, dir_rows[i].res);
      endcase
    end

    for (phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = SEND_IDLE_PCT[phase];
      recv_idle_pct = RECV_IDLE_PCT[phase];
      for (seg = 0; seg < SEGMENTS; seg++) begin
        drain();
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          // Anywhere in the plane, mostly saturating.
          ro      = $urandom;
          io      = $urandom;
          rs      = $urandom;
          is_step = $urandom;
          lim     = $urandom_range(0, 300);
        end else begin
          // A window over the interesting part of the set.
          ro      = -(5 * ONE_Q / 2) + int'($urandom_range(0, 5 * ONE_Q / 2));
          io      = -(3 * ONE_Q / 2) + int'($urandom_range(0, 3 * ONE_Q / 2));
          rs      = $urandom_range(0, 1 << $urandom_range(8, 19));
          is_step = $urandom_range(0, 1 << $urandom_range(8, 19));
          lim     = (sel == 9) ? $urandom_range(256, 1000) : $urandom_range(1, 100);
        end
        if (phase == PHASES - 1 && seg == 0) lim = $urandom_range(1, 16);
        reg_write(REG_REAL_ORIGIN, ro);
        reg_write(REG_IMAG_ORIGIN, io);
        reg_write(REG_REAL_STEP, rs);
        reg_write(REG_IMAG_STEP, is_step);
        reg_write(REG_ITER_LIMIT, lim);
        if (phase == PHASES - 1 && seg == 0) hold_off_request = 1'b1;
        repeat (ITEMS_PER_SEGMENT)
          send_pixel(PIXEL_BITS'($urandom_range(0, PIXEL_MAX)),
                     PIXEL_BITS'($urandom_range(0, PIXEL_MAX)), 1'b0, '0);
      end
    end

    pix_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors += pending_results.size();
    end

    $display("Covered %0d pixel requests and %0d register writes; %0d results compared.",
             pixels_sent, reg_writes, results_checked);
    $display("%0d points escaped, %0d stayed bounded up to their limit.",
             escaped_seen, results_checked - escaped_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/mbet_pkg.sv
rtl/mbet_ifs.sv
rtl/mbet_front.sv
rtl/mbet_queue.sv
rtl/mbet_core.sv
rtl/mandelbrot_escape_time_unit.sv
tb/sv/testbench.sv
